FILE: sv/sbus_frame_parser_assert.svh
// assertion macros shared by the frame parser modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef SBUS_FRAME_PARSER_ASSERT_SVH
`define SBUS_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define SFP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfp assertion failed (same cycle)");

// next-cycle implication
`define SFP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfp assertion failed (next cycle)");

`endif

FILE: sv/sfp_pkg.sv
// types and constants for the frame parser
// used by sfp_core and sbus_frame_parser
package sfp_pkg;

	// fixed output field widths
	localparam int CHAN_IDX_W = 4;
	localparam int CHAN_VAL_W = 11;

	// configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'b1;
	localparam logic [7:0] START_MARKER_RST = 8'hF0;
	localparam logic [7:0] END_MARKER_RST = 8'h00;

	// bit positions of the digital flags
	localparam int FLAG_A_BIT = 7;
	localparam int FLAG_B_BIT = 6;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_DATA  = 2'd1,
		PH_FLAGS = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHANNEL = 2'd0,
		KIND_FLAGS   = 2'd1,
		KIND_GOOD    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	// one result word plus its valid
	typedef struct packed {
		logic                  vld;
		kind_t                 kind;
		logic [CHAN_IDX_W-1:0] idx;
		logic [CHAN_VAL_W-1:0] value;
		logic                  fa;
		logic                  fb;
	} sfp_result_t;

endpackage

FILE: sv/sbus_frame_parser.sv
// Frame parser for a serial servo bus byte stream.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per word.
// Output channel: out_valid / out_stall carry one result word: kind, chan_index,
// chan_value, flag_a, flag_b. Kind 0 is a channel value, 1 the digital flags,
// 2 frame good, 3 frame error. Bytes outside a frame give no word.
// Configuration: cfg_we with cfg_index 0 writes the start marker, index 1 the
// end marker, from cfg_wdata. Write only while no byte is in flight.
// Throughput: one byte per cycle while in_stall is low; each byte is decoded
// combinationally by the frame state machine. A result word is registered
// in the output register, or in the skid stage while the output is stalled.
// Stalls: the output register is backed by a one-word skid stage. in_stall is
// raised only while that skid stage holds a word, so the parser keeps taking
// bytes for one result beyond a stalled output.
// Reset (arst_n low): markers return to 0xF0 / 0x00, the parser hunts for a
// start marker, and both output stages are emptied.
// depends on sfp_pkg, sfp_core and sbus_frame_parser_assert.svh
`include "sbus_frame_parser_assert.svh"

module sbus_frame_parser import sfp_pkg::*; #(
	parameter int NUM_CHANNELS = 16,
	parameter int CHANNEL_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            kind,
	output logic [CHAN_IDX_W-1:0] chan_index,
	output logic [CHAN_VAL_W-1:0] chan_value,
	output logic                  flag_a,
	output logic                  flag_b,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_wdata
);

	logic [7:0]  start_marker_q;
	logic [7:0]  end_marker_q;
	logic        accept;
	sfp_result_t res;
	sfp_result_t out_q;
	sfp_result_t skid_q;
	logic        out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_wdata;
				REG_END_MARKER:   end_marker_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input handshake
	assign in_stall = skid_q.vld;
	assign accept   = in_valid && !in_stall;

	sfp_core #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.start_marker(start_marker_q),
		.end_marker  (end_marker_q),
		.res         (res)
	);

	// output register and skid stage
	assign out_free = !out_q.vld || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (out_free) begin
			if (skid_q.vld) begin
				out_q      <= skid_q;
				skid_q.vld <= 1'b0;
			end else begin
				out_q <= res;
			end
		end else if (res.vld) begin
			skid_q <= res;
		end
	end

	// output ports
	assign out_valid  = out_q.vld;
	assign kind       = out_q.kind;
	assign chan_index = out_q.idx;
	assign chan_value = out_q.value;
	assign flag_a     = out_q.fa;
	assign flag_b     = out_q.fb;

	// checks
	`SFP_ASSERT_IMP(a_skid_behind_out, skid_q.vld, out_q.vld)
	`SFP_ASSERT_NXT(a_skid_drains, skid_q.vld && !out_stall, !skid_q.vld)
	`SFP_ASSERT_IMP(a_flags_only_on_flag_word,
		out_q.vld && (out_q.kind != KIND_FLAGS), !out_q.fa && !out_q.fb)

endmodule

FILE: sv/sfp_core.sv
// frame state machine and channel bit unpacking, one byte per cycle while accept is high
// depends on sfp_pkg and sbus_frame_parser_assert.svh
`include "sbus_frame_parser_assert.svh"

module sfp_core import sfp_pkg::*; #(
	parameter int NUM_CHANNELS = 16,
	parameter int CHANNEL_BITS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  start_marker,
	input  logic [7:0]  end_marker,
	output sfp_result_t res
);

	localparam int DATA_BYTES = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
	localparam int AW = CHANNEL_BITS + 7;
	localparam int HW = $clog2(CHANNEL_BITS + 8);
	localparam int CW = $clog2(NUM_CHANNELS + 1);
	localparam int BW = $clog2(DATA_BYTES + 1);

	phase_t          phase_q, phase_d;
	logic [BW-1:0]   byte_cnt_q, byte_cnt_d;
	logic [AW-1:0]   accum_q, accum_d;
	logic [HW-1:0]   held_q, held_d;
	logic [CW-1:0]   chan_q, chan_d;

	logic [AW-1:0]           merged;
	logic [HW-1:0]           held_sum;
	logic                    emit_ch;
	logic                    last_byte;
	logic [CHANNEL_BITS-1:0] chan_bits;

	// byte merged into the accumulator above the held bits
	assign merged    = accum_q | (AW'(rx_byte) << held_q);
	assign held_sum  = held_q + HW'(8);
	assign emit_ch   = (held_sum >= HW'(CHANNEL_BITS)) && (chan_q < CW'(NUM_CHANNELS));
	assign last_byte = (byte_cnt_q + BW'(1)) >= BW'(DATA_BYTES);
	assign chan_bits = merged[CHANNEL_BITS-1:0];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == start_marker) phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (last_byte) phase_d = PH_FLAGS;
				end
				PH_FLAGS: phase_d = PH_END;
				PH_END:   phase_d = PH_HUNT;
				default:  phase_d = PH_HUNT;
			endcase
		end
	end

	// result and datapath updates
	always_comb begin
		res        = '0;
		res.kind   = KIND_CHANNEL;
		byte_cnt_d = byte_cnt_q;
		accum_d    = accum_q;
		held_d     = held_q;
		chan_d     = chan_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == start_marker) begin
						byte_cnt_d = '0;
						accum_d    = '0;
						held_d     = '0;
						chan_d     = '0;
					end
				end
				PH_DATA: begin
					byte_cnt_d = byte_cnt_q + BW'(1);
					if (emit_ch) begin
						res.vld   = 1'b1;
						res.kind  = KIND_CHANNEL;
						res.idx   = CHAN_IDX_W'(chan_q);
						res.value = CHAN_VAL_W'(chan_bits);
						chan_d    = chan_q + CW'(1);
						held_d    = held_sum - HW'(CHANNEL_BITS);
						accum_d   = merged >> CHANNEL_BITS;
					end else begin
						held_d  = held_sum;
						accum_d = merged;
					end
				end
				PH_FLAGS: begin
					res.vld  = 1'b1;
					res.kind = KIND_FLAGS;
					res.fa   = rx_byte[FLAG_A_BIT];
					res.fb   = rx_byte[FLAG_B_BIT];
				end
				PH_END: begin
					res.vld  = 1'b1;
					res.kind = (rx_byte == end_marker) ? KIND_GOOD : KIND_ERROR;
				end
				default: res.vld = 1'b0;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			byte_cnt_q <= '0;
			accum_q    <= '0;
			held_q     <= '0;
			chan_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			byte_cnt_q <= byte_cnt_d;
			accum_q    <= accum_d;
			held_q     <= held_d;
			chan_q     <= chan_d;
		end
	end

	// checks
	`SFP_ASSERT_IMP(a_held_below_width, 1'b1, held_q < HW'(CHANNEL_BITS))
	`SFP_ASSERT_IMP(a_flags_after_all_data, phase_q == PH_FLAGS,
		byte_cnt_q == BW'(DATA_BYTES))
	`SFP_ASSERT_NXT(a_last_data_to_flags,
		accept && (phase_q == PH_DATA) && last_byte, phase_q == PH_FLAGS)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sbus_frame_parser: directed frame, then random frames
// depends on sfp_pkg and the sbus_frame_parser rtl
module tb;
	import sfp_pkg::*;

	localparam int N_CH = 16;
	localparam int CH_BITS = 11;
	localparam int DATA_BYTES = (N_CH * CH_BITS + 7) / 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int CYCLE_LIMIT = 200000;

	// one result word as the parser should emit it
	typedef struct packed {
		kind_t                 kind;
		logic [CHAN_IDX_W-1:0] idx;
		logic [CHAN_VAL_W-1:0] value;
		logic                  fa;
		logic                  fb;
	} frame_word_t;

	localparam frame_word_t NO_WORD = '0;

	// directed row: byte to send, and optionally the result typed in by hand
	typedef struct {
		logic [7:0]  b;
		bit          typed;
		bit          hit;
		frame_word_t w;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            kind;
	logic [CHAN_IDX_W-1:0] chan_index;
	logic [CHAN_VAL_W-1:0] chan_value;
	logic                  flag_a;
	logic                  flag_b;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [7:0]            cfg_wdata;

	// parser state mirrored by the testbench
	logic [7:0]  start_mk;
	logic [7:0]  end_mk;
	phase_t      ph;
	logic [4:0]  data_cnt;
	logic [17:0] acc;
	logic [4:0]  nbits;
	logic [4:0]  chan_no;

	frame_word_t expected_words[$];
	int          n_fail;
	int          cycle_cnt;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          frame_items;
	row_t        dir_rows [0:26];

	sbus_frame_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.chan_index (chan_index),
		.chan_value (chan_value),
		.flag_a     (flag_a),
		.flag_b     (flag_b),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// random output stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		frame_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: kind %0d", kind);
				n_fail++;
			end else begin
				w = expected_words.pop_front();
				if (kind !== w.kind) begin
					$error("kind: expected %0d, got %0d", w.kind, kind);
					n_fail++;
				end
				if (chan_index !== w.idx) begin
					$error("chan_index: expected %0d, got %0d", w.idx, chan_index);
					n_fail++;
				end
				if (chan_value !== w.value) begin
					$error("chan_value: expected %0d, got %0d", w.value, chan_value);
					n_fail++;
				end
				if (flag_a !== w.fa) begin
					$error("flag_a: expected %0d, got %0d", w.fa, flag_a);
					n_fail++;
				end
				if (flag_b !== w.fb) begin
					$error("flag_b: expected %0d, got %0d", w.fb, flag_b);
					n_fail++;
				end
			end
		end
	end

	// advance the mirrored parser by one byte; returns 1 when a word results
	function automatic bit parse_byte(input logic [7:0] b, output frame_word_t w);
		bit got;
		got = 1'b0;
		w = NO_WORD;
		case (ph)
			PH_HUNT: begin
				if (b == start_mk) begin
					ph = PH_DATA;
					data_cnt = '0;
					acc = '0;
					nbits = '0;
					chan_no = '0;
				end
			end
			PH_DATA: begin
				// lsb-first bit packing, one channel out per completing byte
				acc = acc | (18'(b) << nbits);
				nbits = nbits + 5'd8;
				if (nbits >= CH_BITS && chan_no < N_CH) begin
					w.kind = KIND_CHANNEL;
					w.idx = chan_no[CHAN_IDX_W-1:0];
					w.value = acc[CHAN_VAL_W-1:0];
					got = 1'b1;
					chan_no = chan_no + 5'd1;
					nbits = nbits - 5'(CH_BITS);
					acc = acc >> CH_BITS;
				end
				data_cnt = data_cnt + 5'd1;
				if (data_cnt >= DATA_BYTES)
					ph = PH_FLAGS;
			end
			PH_FLAGS: begin
				w.kind = KIND_FLAGS;
				w.fa = b[FLAG_A_BIT];
				w.fb = b[FLAG_B_BIT];
				got = 1'b1;
				ph = PH_END;
			end
			default: begin
				w.kind = (b == end_mk) ? KIND_GOOD : KIND_ERROR;
				got = 1'b1;
				ph = PH_HUNT;
			end
		endcase
		return got;
	endfunction

	// offer one word on the input, record the expectation once it is taken
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input bit typed_hit = 1'b0, input frame_word_t typed_w = NO_WORD);
		frame_word_t w;
		bit hit;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hit = parse_byte(b, w);
		if (typed) begin
			hit = typed_hit;
			w = typed_w;
		end
		if (hit)
			expected_words.push_back(w);
	endtask

	// random frame: mostly complete, some cut short or closed with a wrong byte
	task automatic send_frame();
		int n_data;
		int fill;
		int k;
		logic [7:0] b;
		n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DATA_BYTES - 1) : DATA_BYTES;
		fill = $urandom_range(0, 7);
		send_byte(start_mk);
		for (k = 0; k < n_data; k++) begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = start_mk;
				3: b = end_mk;
				default: b = 8'($urandom_range(0, 255));
			endcase
			if (fill == 0)
				b = 8'h00;
			else if (fill == 1)
				b = 8'hFF;
			send_byte(b);
		end
		if (n_data == DATA_BYTES) begin
			send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) != 0)
				send_byte(end_mk);
			else
				send_byte(8'($urandom_range(0, 255)));
			frame_items += n_data + 3;
		end else begin
			frame_items += n_data + 1;
		end
	endtask

	// let every expected word arrive, then idle on for bytes with no result
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write both markers while the parser is idle
	task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
		cfg_we <= 1'b1;
		cfg_index <= REG_START_MARKER;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_index <= REG_END_MARKER;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_mk = s;
		end_mk = e;
	endtask

	// one random phase under a given marker setting and idling mix
	task automatic run_phase(input logic [7:0] s, input logic [7:0] e,
			input int tx_pct, input int rx_pct);
		int k;
		wait_idle();
		write_markers(s, e);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		frame_items = 0;
		while (frame_items < ITEMS_PER_PHASE) begin
			if ($urandom_range(0, 99) < 85) begin
				send_frame();
			end else begin
				// line noise between frames
				for (k = $urandom_range(1, 4); k > 0; k--)
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// stimulus
	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_MARKER;
		cfg_wdata = 8'h00;
		n_fail = 0;
		cycle_cnt = 0;
		tx_idle_pct = 26;
		rx_idle_pct = 48;
		frame_items = 0;
		start_mk = START_MARKER_RST;
		end_mk = END_MARKER_RST;
		ph = PH_HUNT;
		data_cnt = '0;
		acc = '0;
		nbits = '0;
		chan_no = '0;

		// directed frame under reset markers: noise, start, data with markers inside,
		// flags, wrong closing byte
		dir_rows = '{
			'{8'h00, 1'b1, 1'b0, NO_WORD},
			'{8'hFF, 1'b1, 1'b0, NO_WORD},
			'{8'hF0, 1'b1, 1'b0, NO_WORD},
			'{8'hFF, 1'b1, 1'b0, NO_WORD},
			'{8'hFF, 1'b1, 1'b1, '{KIND_CHANNEL, 4'd0, 11'h7FF, 1'b0, 1'b0}},
			'{8'hF0, 1'b0, 1'b0, NO_WORD},
			'{8'h00, 1'b0, 1'b0, NO_WORD},
			'{8'h01, 1'b0, 1'b0, NO_WORD},
			'{8'h80, 1'b0, 1'b0, NO_WORD},
			'{8'hAA, 1'b0, 1'b0, NO_WORD},
			'{8'h55, 1'b0, 1'b0, NO_WORD},
			'{8'h0F, 1'b0, 1'b0, NO_WORD},
			'{8'hF0, 1'b0, 1'b0, NO_WORD},
			'{8'h00, 1'b0, 1'b0, NO_WORD},
			'{8'hFF, 1'b0, 1'b0, NO_WORD},
			'{8'h7F, 1'b0, 1'b0, NO_WORD},
			'{8'hFE, 1'b0, 1'b0, NO_WORD},
			'{8'h3C, 1'b0, 1'b0, NO_WORD},
			'{8'hC3, 1'b0, 1'b0, NO_WORD},
			'{8'h00, 1'b0, 1'b0, NO_WORD},
			'{8'hF0, 1'b0, 1'b0, NO_WORD},
			'{8'h12, 1'b0, 1'b0, NO_WORD},
			'{8'h34, 1'b0, 1'b0, NO_WORD},
			'{8'h56, 1'b0, 1'b0, NO_WORD},
			'{8'h78, 1'b0, 1'b0, NO_WORD},
			'{8'h80, 1'b1, 1'b1, '{KIND_FLAGS, 4'd0, 11'd0, 1'b1, 1'b0}},
			'{8'h5A, 1'b1, 1'b1, '{KIND_ERROR, 4'd0, 11'd0, 1'b0, 1'b0}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 27; i++)
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].w);

		// random phases: marker extremes, random, equal and reset markers, and idling mixes
		run_phase(8'h00, 8'hFF, 26, 48);
		run_phase(8'hFF, 8'h00, 26, 48);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 48, 26);
		run_phase(8'h7E, 8'h7E, 48, 26);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
		run_phase(START_MARKER_RST, END_MARKER_RST, 0, 0);
		wait_idle();

		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/sfp_pkg.sv
sv/sfp_core.sv
sv/sbus_frame_parser.sv
tb/tb.sv
